@@ hdl/smm_pkg.sv @@
// smm_pkg: request and result types and opcodes of the square matrix multiplier.
// Used by smm_mac and square_matrix_multiply_top; no dependencies.
`default_nettype none

package smm_pkg;

  localparam logic [1:0] OP_LOAD_A = 2'd0;
  localparam logic [1:0] OP_LOAD_B = 2'd1;
  localparam logic [1:0] OP_START  = 2'd2;

  typedef struct packed {
    logic [1:0]         op;
    logic [1:0]         row;
    logic [1:0]         col;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]         out_row;
    logic [1:0]         out_col;
    logic signed [31:0] product;
    logic               last;
  } rsp_t;

  // bookkeeping that rides along with each product term
  typedef struct packed {
    logic       first;
    logic       last_k;
    logic       last_elem;
    logic [1:0] row;
    logic [1:0] col;
  } tag_t;

endpackage

`default_nettype wire

@@ hdl/square_matrix_multiply_top.sv @@
// square_matrix_multiply_top: element stores for A and B, the row/column/k
// sequencer and the request port. Depends on smm_pkg and smm_mac.
`default_nettype none

// Load requests (op 0 for A, op 1 for B) are taken one per cycle while busy is
// low and write one element into the A or B memory; a load whose row or col is
// not below MAT_SIZE is dropped, and op 3 is ignored. A start request raises busy
// and runs one multiply-accumulate unit over all MAT_SIZE^3 product terms, one
// term per cycle, with both memories read once per cycle. Results appear in
// row-major order, and busy drops in the cycle after the result with last set.
// Each result is held on rsp for exactly one cycle, marked by strobe; there is
// no way to hold it off.
module square_matrix_multiply_top #(
  parameter int MAT_SIZE = 4
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire smm_pkg::req_t req,
  output logic               busy,
  output logic               strobe,
  output smm_pkg::rsp_t      rsp
);

  localparam int DEPTH  = MAT_SIZE * MAT_SIZE;
  localparam int IDX_W  = (MAT_SIZE > 1) ? $clog2(MAT_SIZE) : 1;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [ADDR_W-1:0] DIM = ADDR_W'(MAT_SIZE);
  localparam logic [IDX_W-1:0]  IDX_MAX = IDX_W'(MAT_SIZE - 1);

  logic [31:0] mem_a [DEPTH];
  logic [31:0] mem_b [DEPTH];

  logic              accept;
  logic              in_range;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] a_addr;
  logic [ADDR_W-1:0] b_addr;
  logic [31:0]       a_rd;
  logic [31:0]       b_rd;

  logic             run;
  logic [IDX_W-1:0] r;
  logic [IDX_W-1:0] c;
  logic [IDX_W-1:0] k;
  logic             r_last;
  logic             c_last;
  logic             k_last;

  logic          rd_valid;
  smm_pkg::tag_t rd_tag;

  assign accept   = start && !busy;
  assign in_range = (32'(req.row) < MAT_SIZE) && (32'(req.col) < MAT_SIZE);
  assign wr_addr  = ADDR_W'(ADDR_W'(req.row) * DIM + ADDR_W'(req.col));
  assign a_addr   = ADDR_W'(ADDR_W'(r) * DIM + ADDR_W'(k));
  assign b_addr   = ADDR_W'(ADDR_W'(k) * DIM + ADDR_W'(c));
  assign r_last   = (r == IDX_MAX);
  assign c_last   = (c == IDX_MAX);
  assign k_last   = (k == IDX_MAX);

  // stores are never written while a multiply runs, so reads need no forwarding
  always_ff @(posedge clk) begin
    if (accept && in_range && req.op == smm_pkg::OP_LOAD_A) begin
      mem_a[wr_addr] <= req.value;
    end
    if (accept && in_range && req.op == smm_pkg::OP_LOAD_B) begin
      mem_b[wr_addr] <= req.value;
    end
    a_rd <= mem_a[a_addr];
    b_rd <= mem_b[b_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      run      <= 1'b0;
      r        <= '0;
      c        <= '0;
      k        <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= run;
      if (accept && req.op == smm_pkg::OP_START) begin
        busy <= 1'b1;
        run  <= 1'b1;
        r    <= '0;
        c    <= '0;
        k    <= '0;
      end else begin
        if (strobe && rsp.last) begin
          busy <= 1'b0;
        end
        if (run) begin
          if (k_last) begin
            k <= '0;
            if (c_last) begin
              c <= '0;
              if (r_last) begin
                run <= 1'b0;
              end else begin
                r <= r + 1'b1;
              end
            end else begin
              c <= c + 1'b1;
            end
          end else begin
            k <= k + 1'b1;
          end
        end
      end
    end
    // tag lines up with the registered memory data
    rd_tag.first     <= (k == '0);
    rd_tag.last_k    <= k_last;
    rd_tag.last_elem <= r_last && c_last && k_last;
    rd_tag.row       <= 2'(r);
    rd_tag.col       <= 2'(c);
  end

  smm_mac u_mac (
    .clk      (clk),
    .rst      (rst),
    .in_valid (rd_valid),
    .a        (a_rd),
    .b        (b_rd),
    .tag      (rd_tag),
    .rsp      (rsp),
    .strobe   (strobe)
  );

  a_run_in_busy: assert property (@(posedge clk) disable iff (rst)
    run |-> busy)
    else $error("sequencer running while not busy");

  a_busy_ends_on_last: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> $past(strobe) && $past(rsp.last))
    else $error("busy dropped before the last result");

  a_strobe_in_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("result outside a multiply");

endmodule

`default_nettype wire

@@ hdl/smm_mac.sv @@
// smm_mac: registered 32x32 multiplier (low word) followed by the accumulator
// that forms one dot product and emits it as a result. Depends on smm_pkg.
`default_nettype none

module smm_mac (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic [31:0]   a,
  input  wire logic [31:0]   b,
  input  wire smm_pkg::tag_t tag,
  output smm_pkg::rsp_t      rsp,
  output logic               strobe
);

  logic          p_valid;
  logic [31:0]   prod;
  smm_pkg::tag_t p_tag;
  logic [31:0]   acc;
  logic [31:0]   acc_next;

  always_comb begin
    acc_next = p_tag.first ? prod : acc + prod;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      strobe  <= 1'b0;
    end else begin
      p_valid <= in_valid;
      strobe  <= p_valid && p_tag.last_k;
    end
    // only the low word of the product matters, the sum wraps mod 2^32
    prod  <= a * b;
    p_tag <= tag;
    if (p_valid) begin
      acc <= acc_next;
    end
    rsp.out_row <= p_tag.row;
    rsp.out_col <= p_tag.col;
    rsp.product <= acc_next;
    rsp.last    <= p_tag.last_elem;
  end

  a_strobe_from_term: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(p_valid) && $past(p_tag.last_k))
    else $error("result without a closing product term");

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
// tb_top: self-checking testbench for square_matrix_multiply_top. It loads A and B,
// runs multiplies and checks every product element against a predicted matrix.
// Depends on smm_pkg and the multiplier RTL.
module tb_top;

  localparam int MAT_SIZE = 4;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 330;
  localparam int REPORT_LIMIT = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  smm_pkg::req_t req = '0;
  logic busy;
  logic strobe;
  smm_pkg::rsp_t rsp;

  // predicted contents of the two element stores
  logic [31:0] a_elem [MAT_SIZE][MAT_SIZE];
  logic [31:0] b_elem [MAT_SIZE][MAT_SIZE];
  bit a_written [MAT_SIZE][MAT_SIZE];
  bit b_written [MAT_SIZE][MAT_SIZE];

  smm_pkg::rsp_t product_q[$];
  int fail_count = 0;
  bit start_level = 1'b0;
  bit no_gaps = 1'b0;

  square_matrix_multiply_top #(.MAT_SIZE(MAT_SIZE)) u_top (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .req    (req),
    .busy   (busy),
    .strobe (strobe),
    .rsp    (rsp)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #1000000;
    $display("FAILURE");
    $finish;
  end

  function automatic bit all_loaded();
    bit ok;
    ok = 1'b1;
    for (int r = 0; r < MAT_SIZE; r++)
      for (int c = 0; c < MAT_SIZE; c++)
        ok &= a_written[r][c] & b_written[r][c];
    return ok;
  endfunction

  // queue the whole of A*B in row-major order, sums wrap at 32 bits
  task automatic push_product_matrix();
    smm_pkg::rsp_t elem;
    logic [31:0] acc;
    for (int r = 0; r < MAT_SIZE; r++) begin
      for (int c = 0; c < MAT_SIZE; c++) begin
        acc = '0;
        for (int k = 0; k < MAT_SIZE; k++)
          acc = acc + a_elem[r][k] * b_elem[k][c];
        elem.out_row = r[1:0];
        elem.out_col = c[1:0];
        elem.product = acc;
        elem.last    = (r == MAT_SIZE - 1) && (c == MAT_SIZE - 1);
        product_q.push_back(elem);
      end
    end
  endtask

  task automatic apply_request(smm_pkg::req_t r);
    case (r.op)
      smm_pkg::OP_LOAD_A: begin
        if (r.row < MAT_SIZE && r.col < MAT_SIZE) begin
          a_elem[r.row][r.col] = r.value;
          a_written[r.row][r.col] = 1'b1;
        end
      end
      smm_pkg::OP_LOAD_B: begin
        if (r.row < MAT_SIZE && r.col < MAT_SIZE) begin
          b_elem[r.row][r.col] = r.value;
          b_written[r.row][r.col] = 1'b1;
        end
      end
      smm_pkg::OP_START: push_product_matrix();
      default: ;
    endcase
  endtask

  // only one update of start per time step
  task automatic drive_start(bit level);
    if (level != start_level) begin
      start <= level;
      start_level = level;
    end
  endtask

  task automatic send_request(smm_pkg::req_t r);
    drive_start(1'b1);
    req <= r;
    do @(posedge clk); while (busy);
    apply_request(r);
  endtask

  function automatic int gap_len();
    int u;
    u = $urandom_range(0, 99);
    if (u < 55) return 0;
    if (u < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  task automatic pace();
    int n;
    n = no_gaps ? 0 : gap_len();
    if (n > 0) begin
      drive_start(1'b0);
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic issue(logic [1:0] op, logic [1:0] row, logic [1:0] col, logic [31:0] value);
    smm_pkg::req_t r;
    r.op = op;
    r.row = row;
    r.col = col;
    r.value = value;
    send_request(r);
    pace();
  endtask

  task automatic drain();
    drive_start(1'b0);
    while (product_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'($urandom_range(0, 16)) - 32'd8;
      default: return $urandom;
    endcase
  endfunction

  always @(posedge clk) begin
    smm_pkg::rsp_t want;
    if (!rst && strobe) begin
      if (product_q.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("unexpected result: row %0d col %0d product %0d last %0b",
                   rsp.out_row, rsp.out_col, rsp.product, rsp.last);
      end else begin
        want = product_q.pop_front();
        if (rsp.out_row !== want.out_row || rsp.out_col !== want.out_col ||
            rsp.product !== want.product || rsp.last !== want.last) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("mismatch: exp %0d,%0d %0d last %0b, got %0d,%0d %0d last %0b",
                     want.out_row, want.out_col, want.product, want.last,
                     rsp.out_row, rsp.out_col, rsp.product, rsp.last);
        end
      end
    end
  end

  // full loads of both matrices from a set of corner values, then one multiply
  task automatic test_extreme_values();
    logic [31:0] corners [8];
    corners = '{32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h0000_0000,
                32'h0000_0001, 32'h5555_5555, 32'haaaa_aaaa, 32'h0000_0002};
    for (int r = 0; r < MAT_SIZE; r++)
      for (int c = 0; c < MAT_SIZE; c++)
        issue(smm_pkg::OP_LOAD_A, r[1:0], c[1:0], corners[(r * MAT_SIZE + c) % 8]);
    for (int r = 0; r < MAT_SIZE; r++)
      for (int c = 0; c < MAT_SIZE; c++)
        issue(smm_pkg::OP_LOAD_B, r[1:0], c[1:0], corners[(r * MAT_SIZE + c + 3) % 8]);
    issue(smm_pkg::OP_START, 2'd0, 2'd0, 32'd0);
    drain();
  endtask

  // op 3 must leave both stores untouched
  task automatic test_unused_op();
    issue(OP_UNUSED, 2'd0, 2'd0, 32'hffff_ffff);
    issue(OP_UNUSED, 2'd3, 2'd3, 32'h8000_0000);
    issue(OP_UNUSED, 2'($urandom), 2'($urandom), $urandom);
    issue(smm_pkg::OP_START, 2'd3, 2'd3, 32'h1234_5678);
    drain();
  endtask

  // overflowing products and back-to-back starts
  task automatic test_wrap_and_restart();
    issue(smm_pkg::OP_LOAD_A, 2'd0, 2'd0, 32'h7fff_ffff);
    issue(smm_pkg::OP_LOAD_B, 2'd0, 2'd0, 32'h7fff_ffff);
    issue(smm_pkg::OP_LOAD_A, 2'd3, 2'd3, 32'h8000_0000);
    issue(smm_pkg::OP_LOAD_B, 2'd3, 2'd3, 32'h8000_0000);
    issue(smm_pkg::OP_START, 2'd0, 2'd0, 32'd0);
    issue(smm_pkg::OP_START, 2'd1, 2'd2, 32'd0);
    drain();
  endtask

  task automatic test_random_traffic();
    int done;
    int sel;
    bit pick_a;
    done = 0;
    while (done < RANDOM_ITEMS) begin
      no_gaps = (done % 50) < 12;
      sel = $urandom_range(0, 99);
      if (sel < 3) begin
        pick_a = $urandom_range(0, 1);
        for (int r = 0; r < MAT_SIZE; r++)
          for (int c = 0; c < MAT_SIZE; c++)
            issue(pick_a ? smm_pkg::OP_LOAD_A : smm_pkg::OP_LOAD_B,
                  r[1:0], c[1:0], rand_value());
        done += MAT_SIZE * MAT_SIZE;
      end else if (sel < 11 && all_loaded()) begin
        issue(smm_pkg::OP_START, 2'($urandom), 2'($urandom), $urandom);
        done++;
        if ($urandom_range(0, 4) == 0)
          drain();
      end else if (sel < 15) begin
        issue(OP_UNUSED, 2'($urandom), 2'($urandom), $urandom);
      end else begin
        issue($urandom_range(0, 1) ? smm_pkg::OP_LOAD_A : smm_pkg::OP_LOAD_B,
              2'($urandom), 2'($urandom), rand_value());
        done++;
      end
    end
    no_gaps = 1'b0;
    issue(smm_pkg::OP_START, 2'd0, 2'd0, 32'd0);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extreme_values();
    test_unused_op();
    test_wrap_and_restart();
    test_random_traffic();
    drain();
    repeat (MAT_SIZE + 8) @(posedge clk);
    fail_count += product_q.size();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/smm_pkg.sv
hdl/smm_mac.sv
hdl/square_matrix_multiply_top.sv
test/tb_top.sv
